/* hdl/pbc_pkg.sv */
package pbc_pkg;

	localparam int ORIG_W     = 16;
	localparam int PROC_W     = 8;
	localparam int X_W        = 12;
	localparam int MIX_W      = 17;
	localparam int GAIN_W     = 16;
	localparam int FW_W       = 13;
	localparam int HALF_W     = 13;
	localparam int IDX_W      = 3;
	localparam int CFG_DATA_W = 17;

	// Internal arithmetic widths.
	localparam int DELTA_W  = 25;
	localparam int BASE_W   = 17;
	localparam int FACTOR_W = 32;
	localparam int PROD_W   = 58;
	localparam int NUM_W    = 62;
	localparam int QUO_W    = 23;
	localparam int RECIP_W  = 16;

	localparam int FRAC_SHIFT  = 28;
	localparam int SCALE_SHIFT = 16;
	localparam int RECIP_SHIFT = 23;

	localparam logic [MIX_W-1:0]   MIX_ONE    = 17'h10000;
	localparam logic [GAIN_W-1:0]  GAIN_ONE   = 16'd4096;
	localparam logic [ORIG_W-1:0]  WHITE_BYTE = 16'd255;
	localparam logic [ORIG_W-1:0]  WHITE_WIDE = 16'd32768;
	localparam logic [RECIP_W-1:0] RECIP_255  = 16'd32896;
	localparam logic [FW_W-1:0]    WIDTH_RST  = 13'd4096;

	// Half of the 255 * 2^28 denominator, for round half up.
	localparam logic signed [NUM_W-1:0] ROUND_HALF = NUM_W'(255) <<< (FRAC_SHIFT - 1);

	localparam logic [1:0] VIEW_BLEND = 2'd0;
	localparam logic [1:0] VIEW_DIFF  = 2'd1;
	localparam logic [1:0] VIEW_SPLIT = 2'd2;
	localparam logic [1:0] VIEW_SPARE = 2'd3;

	localparam logic [IDX_W-1:0] REG_DEPTH = 3'd0;
	localparam logic [IDX_W-1:0] REG_VIEW  = 3'd1;
	localparam logic [IDX_W-1:0] REG_MIX   = 3'd2;
	localparam logic [IDX_W-1:0] REG_GAIN  = 3'd3;
	localparam logic [IDX_W-1:0] REG_WIDTH = 3'd4;

	typedef struct packed {
		logic              depth;
		logic [1:0]        view;
		logic [MIX_W-1:0]  mix;
		logic [GAIN_W-1:0] gain;
		logic [HALF_W-1:0] half;
	} cfg_snap_t;

	typedef struct packed {
		logic signed [DELTA_W-1:0] delta;
		logic [BASE_W-1:0]         base;
		logic [ORIG_W-1:0]         pass;
	} chan_op_t;

	typedef struct packed {
		logic [FACTOR_W-1:0] factor;
		logic [ORIG_W-1:0]   white;
		logic                scaled;
		logic                use_pass;
	} chan_ctl_t;

endpackage

/* hdl/pixel_blend_compositor.sv */
// Per-pixel compositor of an original pixel and a processed RGB byte triple.
// Input channel: drive the pixel fields with start high; a word is taken at
// every rising edge where start is high and busy is low. busy stays low, so
// one pixel can be taken in every cycle, back to back.
// Result channel: done is high for exactly one cycle with out_a, out_r,
// out_g and out_b valid in that cycle. The receiver cannot stall, and no
// stall is needed: results leave in the order pixels arrived.
// Seven register stages (two front stages, then gain product, numerator add,
// clamp and round, reciprocal multiply, fixup) lie between an accepted pixel
// and done. Throughput is one pixel per cycle, since each stage takes a new
// word in every cycle.
// Configuration channel: cfg_valid with cfg_index and cfg_data writes one
// register; cfg_ready is always high. Index 0 sample depth, 1 view mode,
// 2 mix, 3 intensity gain, 4 frame width. Write only while the pipeline is
// empty; each pixel takes the settings present when it is accepted.
// Reset clears the pipeline valid bits and sets depth 8 bit, processed
// blend, full mix, unit gain and width 4096. There is no clearing pass.
module pixel_blend_compositor import pbc_pkg::*; #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [ORIG_W-1:0]     orig_a,
	input  logic [ORIG_W-1:0]     orig_r,
	input  logic [ORIG_W-1:0]     orig_g,
	input  logic [ORIG_W-1:0]     orig_b,
	input  logic [PROC_W-1:0]     proc_r,
	input  logic [PROC_W-1:0]     proc_g,
	input  logic [PROC_W-1:0]     proc_b,
	input  logic [X_W-1:0]        pixel_x,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  done,
	output logic [ORIG_W-1:0]     out_a,
	output logic [ORIG_W-1:0]     out_r,
	output logic [ORIG_W-1:0]     out_g,
	output logic [ORIG_W-1:0]     out_b
);

	cfg_snap_t         snap;
	logic              accept;
	logic              valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	logic [ORIG_W-1:0] alpha_s2, alpha_s3, alpha_s4, alpha_s5, alpha_s6, alpha_s7;
	chan_ctl_t         ctl_s2;
	chan_op_t [2:0]    op_s2;
	logic [2:0][ORIG_W-1:0] value_s7;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	pbc_cfg #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.snap      (snap)
	);

	pbc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.snap     (snap),
		.alpha    (orig_a),
		.orig     ({orig_b, orig_g, orig_r}),
		.proc     ({proc_b, proc_g, proc_r}),
		.x        (pixel_x),
		.valid_s2 (valid_s2),
		.alpha_s2 (alpha_s2),
		.ctl_s2   (ctl_s2),
		.op_s2    (op_s2)
	);

	for (genvar k = 0; k < 3; k++) begin : g_chan
		pbc_chan u_chan (
			.clk      (clk),
			.op       (op_s2[k]),
			.ctl      (ctl_s2),
			.value_s7 (value_s7[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	// Alpha rides alongside the channel pipeline unchanged.
	always_ff @(posedge clk) begin
		alpha_s3 <= alpha_s2;
		alpha_s4 <= alpha_s3;
		alpha_s5 <= alpha_s4;
		alpha_s6 <= alpha_s5;
		alpha_s7 <= alpha_s6;
	end

	assign done  = valid_s7;
	assign out_a = alpha_s7;
	assign out_r = value_s7[0];
	assign out_g = value_s7[1];
	assign out_b = value_s7[2];

endmodule

/* hdl/pbc_cfg.sv */
module pbc_cfg import pbc_pkg::*; #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_snap_t             snap
);

	logic              depth_q;
	logic [1:0]        view_q;
	logic [MIX_W-1:0]  mix_q;
	logic [GAIN_W-1:0] gain_q;
	logic [FW_W-1:0]   width_q;
	logic [FW_W-1:0]   width_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= 1'b0;
			view_q  <= VIEW_BLEND;
			mix_q   <= MIX_ONE;
			gain_q  <= GAIN_ONE;
			width_q <= WIDTH_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DEPTH: depth_q <= cfg_data[0];
				REG_VIEW:  view_q  <= cfg_data[1:0];
				REG_MIX:   mix_q   <= cfg_data[MIX_W-1:0];
				REG_GAIN:  gain_q  <= cfg_data[GAIN_W-1:0];
				REG_WIDTH: width_q <= cfg_data[FW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		width_sat  = (32'(width_q) > MAX_WIDTH) ? FW_W'(MAX_WIDTH) : width_q;
		snap.depth = depth_q;
		// The spare view code behaves as the processed blend.
		snap.view  = (view_q == VIEW_SPARE) ? VIEW_BLEND : view_q;
		snap.mix   = (mix_q > MIX_ONE) ? MIX_ONE : mix_q;
		snap.gain  = gain_q;
		snap.half  = HALF_W'(width_sat >> 1);
	end

endmodule

/* hdl/pbc_front.sv */
module pbc_front import pbc_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  cfg_snap_t                    snap,
	input  logic [ORIG_W-1:0]            alpha,
	input  logic [2:0][ORIG_W-1:0]       orig,
	input  logic [2:0][PROC_W-1:0]       proc,
	input  logic [X_W-1:0]               x,
	output logic                         valid_s2,
	output logic [ORIG_W-1:0]            alpha_s2,
	output chan_ctl_t                    ctl_s2,
	output chan_op_t [2:0]               op_s2
);

	logic                   valid_s1;
	logic [ORIG_W-1:0]      alpha_s1;
	logic [2:0][ORIG_W-1:0] orig_s1;
	logic [2:0][PROC_W-1:0] proc_s1;
	logic [X_W-1:0]         x_s1;
	cfg_snap_t              snap_s1;

	logic [ORIG_W-1:0]      white;
	logic                   bypass;
	logic                   use_pass;
	logic                   left_side;
	logic [FACTOR_W-1:0]    factor;
	chan_op_t [2:0]         op;
	logic [2:0][22:0]       proc_w;
	logic [2:0][23:0]       orig_255;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	// At eight-bit depth only the low byte of each original sample counts.
	always_ff @(posedge clk) begin
		if (accept) begin
			alpha_s1 <= snap.depth ? alpha : {8'b0, alpha[7:0]};
			for (int k = 0; k < 3; k++) begin
				orig_s1[k] <= snap.depth ? orig[k] : {8'b0, orig[k][7:0]};
			end
			proc_s1 <= proc;
			x_s1    <= x;
			snap_s1 <= snap;
		end
	end

	always_comb begin
		white     = snap_s1.depth ? WHITE_WIDE : WHITE_BYTE;
		bypass    = (snap_s1.view == VIEW_BLEND) && (snap_s1.mix == '0);
		left_side = {1'b0, x_s1} < snap_s1.half;
		use_pass  = bypass || ((snap_s1.view == VIEW_SPLIT) && ({1'b0, x_s1} <= snap_s1.half));

		case (snap_s1.view)
			VIEW_BLEND: factor = FACTOR_W'(snap_s1.gain) * FACTOR_W'(snap_s1.mix);
			VIEW_DIFF:  factor = FACTOR_W'({snap_s1.gain, 3'b0}) + FACTOR_W'({snap_s1.gain, 1'b0});
			default:    factor = FACTOR_W'(snap_s1.gain);
		endcase

		for (int k = 0; k < 3; k++) begin
			// Difference scaled by 255 * white: p * white - 255 * o.
			proc_w[k]   = snap_s1.depth ? {proc_s1[k], 15'b0}
			                            : ({7'b0, proc_s1[k], 8'b0} - {15'b0, proc_s1[k]});
			orig_255[k] = {orig_s1[k], 8'b0} - {8'b0, orig_s1[k]};
			op[k].delta = $signed({2'b0, proc_w[k]}) - $signed({1'b0, orig_255[k]});
			op[k].base  = (snap_s1.view == VIEW_DIFF) ? {1'b0, white} : {orig_s1[k], 1'b0};
			if (bypass) begin
				op[k].pass = orig_s1[k];
			end else if (left_side) begin
				op[k].pass = (orig_s1[k] < white) ? orig_s1[k] : white;
			end else begin
				op[k].pass = white;
			end
		end
	end

	always_ff @(posedge clk) begin
		alpha_s2        <= alpha_s1;
		op_s2           <= op;
		ctl_s2.factor   <= factor;
		ctl_s2.white    <= white;
		ctl_s2.scaled   <= snap_s1.view != VIEW_BLEND;
		ctl_s2.use_pass <= use_pass;
	end

endmodule

/* hdl/pbc_chan.sv */
module pbc_chan import pbc_pkg::*; (
	input  logic              clk,
	input  chan_op_t          op,
	input  chan_ctl_t         ctl,
	output logic [ORIG_W-1:0] value_s7
);

	logic signed [PROD_W-1:0] prod_s3;
	logic [BASE_W-1:0]        base_s3;
	logic [ORIG_W-1:0]        pass_s3, pass_s4, pass_s5, pass_s6;
	logic [ORIG_W-1:0]        white_s3, white_s4, white_s5, white_s6;
	logic                     use_s3, use_s4, use_s5, use_s6;
	logic                     scaled_s3;

	logic signed [NUM_W-1:0]  num_s4;
	logic                     lo_s5, lo_s6, hi_s5, hi_s6;
	logic [QUO_W-1:0]         u_s5, u_s6;
	logic [ORIG_W-1:0]        q0_s6;

	logic [24:0]              base_255;
	logic signed [NUM_W-1:0]  base_term, prod_term, limit, rounded;
	logic [23:0]              white_255;
	logic [QUO_W+RECIP_W-1:0] recip_prod;
	logic [23:0]              q0_255;
	logic [23:0]              rem;
	logic [ORIG_W-1:0]        quo;

	// Stage 3: the difference times the gain factor.
	always_ff @(posedge clk) begin
		prod_s3   <= $signed(op.delta) * $signed({1'b0, ctl.factor});
		base_s3   <= op.base;
		pass_s3   <= op.pass;
		white_s3  <= ctl.white;
		use_s3    <= ctl.use_pass;
		scaled_s3 <= ctl.scaled;
	end

	// Stage 4: numerator over the common denominator 255 * 2^28.
	always_comb begin
		base_255  = {base_s3, 8'b0} - {8'b0, base_s3};
		base_term = $signed(NUM_W'({base_255, 27'b0}));
		prod_term = scaled_s3 ? (NUM_W'(prod_s3) <<< SCALE_SHIFT) : NUM_W'(prod_s3);
	end

	always_ff @(posedge clk) begin
		num_s4   <= base_term + prod_term;
		pass_s4  <= pass_s3;
		white_s4 <= white_s3;
		use_s4   <= use_s3;
	end

	// Stage 5: clamp tests and the rounded quotient by 2^28.
	always_comb begin
		white_255 = {white_s4, 8'b0} - {8'b0, white_s4};
		limit     = $signed(NUM_W'({white_255, 28'b0}));
		rounded   = num_s4 + ROUND_HALF;
	end

	always_ff @(posedge clk) begin
		lo_s5    <= num_s4 <= 0;
		hi_s5    <= num_s4 >= limit;
		u_s5     <= rounded[FRAC_SHIFT +: QUO_W];
		pass_s5  <= pass_s4;
		white_s5 <= white_s4;
		use_s5   <= use_s4;
	end

	// Stage 6: reciprocal estimate of u / 255, low by at most one.
	assign recip_prod = QUO_W'(u_s5) * RECIP_255;

	always_ff @(posedge clk) begin
		q0_s6    <= recip_prod[RECIP_SHIFT +: ORIG_W];
		u_s6     <= u_s5;
		lo_s6    <= lo_s5;
		hi_s6    <= hi_s5;
		pass_s6  <= pass_s5;
		white_s6 <= white_s5;
		use_s6   <= use_s5;
	end

	// Stage 7: one correction step, then pick the final sample.
	always_comb begin
		q0_255 = {q0_s6, 8'b0} - {8'b0, q0_s6};
		rem    = {1'b0, u_s6} - q0_255;
		quo    = (rem >= 24'd255) ? q0_s6 + 16'd1 : q0_s6;
	end

	always_ff @(posedge clk) begin
		if (use_s6) begin
			value_s7 <= pass_s6;
		end else if (lo_s6) begin
			value_s7 <= '0;
		end else if (hi_s6) begin
			value_s7 <= white_s6;
		end else begin
			value_s7 <= quo;
		end
	end

endmodule
